@@ design/xrm_pkg.sv @@
// Shared types, constants and generator step functions for the xorshift block.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package xrm_pkg;

    // Item kinds.
    typedef enum logic [2:0] {
        KIND_DRAW32 = 3'd0,
        KIND_DRAW64 = 3'd1,
        KIND_SEED32 = 3'd2,
        KIND_SEED64 = 3'd3,
        KIND_STEP32 = 3'd4,
        KIND_STEP64 = 3'd5
    } t_kind;

    // Generator reset seeds.
    localparam logic [31:0] NARROW_RESET = 32'h2545_F491;
    localparam logic [63:0] WIDE_RESET   = 64'h9E37_79B9_7F4A_7C15;

    // Shift amounts of the two generators.
    localparam int unsigned N_SHR = 25;
    localparam int unsigned N_SHL_A = 7;
    localparam int unsigned N_SHL_B = 19;
    localparam int unsigned W_SHR = 51;
    localparam int unsigned W_SHL_A = 13;
    localparam int unsigned W_SHL_B = 29;

    // Work handed from the front end to the back end.
    typedef struct packed {
        logic        need_div;   // Reduce dividend by divisor.
        logic        narrow;     // Only the low 32 bits of dividend count.
        logic [63:0] dividend;   // Stepped value, or the result value itself.
        logic [63:0] divisor;
        logic [63:0] next_seed;
    } t_job;

    // One step of the 32-bit generator with inverted shift terms.
    function automatic logic [31:0] f_adv_narrow(input logic [31:0] s);
        logic [31:0] t;
        t = s;
        t = t ^ ~(t >> N_SHR);
        t = t ^ ~(t << N_SHL_A);
        t = t ^ ~(t << N_SHL_B);
        return t;
    endfunction

    // One step of the 64-bit generator with inverted shift terms.
    function automatic logic [63:0] f_adv_wide(input logic [63:0] s);
        logic [63:0] t;
        t = s;
        t = t ^ ~(t >> W_SHR);
        t = t ^ ~(t << W_SHL_A);
        t = t ^ ~(t << W_SHL_B);
        return t;
    endfunction

endpackage

`default_nettype wire

@@ design/xrm_front.sv @@
// Front end: accepts requests, holds both generator states and builds jobs.
// Depends on xrm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xrm_front
    import xrm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic [2:0]  i_kind,
    input  wire logic [63:0] i_modulus,
    input  wire logic [63:0] i_seed_value,
    output t_job             o_job
);

    logic [31:0] r_narrow;
    logic [31:0] n_narrow;
    logic [63:0] r_wide;
    logic [63:0] n_wide;
    logic [31:0] w_step_narrow;
    logic [63:0] w_step_wide;
    logic [31:0] w_mod32;
    logic [31:0] w_seed32;

    assign w_mod32  = i_modulus[31:0];
    assign w_seed32 = i_seed_value[31:0];

    // The draw kinds step the internal state, the step kinds step the supplied seed.
    always_comb begin
        if (i_kind == KIND_STEP32) begin
            w_step_narrow = f_adv_narrow(w_seed32);
        end else begin
            w_step_narrow = f_adv_narrow(r_narrow);
        end
        if (i_kind == KIND_STEP64) begin
            w_step_wide = f_adv_wide(i_seed_value);
        end else begin
            w_step_wide = f_adv_wide(r_wide);
        end
    end

    // Classify the request into a job and the next generator states.
    always_comb begin
        n_narrow = r_narrow;
        n_wide   = r_wide;
        o_job    = '0;
        case (t_kind'(i_kind))
            KIND_DRAW32, KIND_STEP32: begin
                if (i_kind == KIND_DRAW32) begin
                    n_narrow = w_step_narrow;
                end
                o_job.need_div  = (w_mod32 != 32'd0);
                o_job.narrow    = 1'b1;
                o_job.dividend  = {32'd0, w_step_narrow};
                o_job.divisor   = {32'd0, w_mod32};
                o_job.next_seed = {32'd0, w_step_narrow};
            end
            KIND_DRAW64, KIND_STEP64: begin
                if (i_kind == KIND_DRAW64) begin
                    n_wide = w_step_wide;
                end
                o_job.need_div  = (i_modulus != 64'd0);
                o_job.dividend  = w_step_wide;
                o_job.divisor   = i_modulus;
                o_job.next_seed = w_step_wide;
            end
            KIND_SEED32: begin
                n_narrow        = w_seed32;
                o_job.dividend  = {32'd0, r_narrow};
                o_job.next_seed = {32'd0, w_seed32};
            end
            KIND_SEED64: begin
                n_wide          = i_seed_value;
                o_job.dividend  = r_wide;
                o_job.next_seed = i_seed_value;
            end
            default: begin
                o_job = '0;
            end
        endcase
    end

    // Generator state registers, updated only on an accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_narrow <= NARROW_RESET;
            r_wide   <= WIDE_RESET;
        end else if (i_accept) begin
            r_narrow <= n_narrow;
            r_wide   <= n_wide;
        end
    end

endmodule

`default_nettype wire

@@ design/xrm_fifo.sv @@
// Short job queue between the front end and the back end.
// Depends on xrm_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none

module xrm_fifo
    import xrm_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_rd,
    output t_job      o_job,
    output logic      o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue fill count exceeds depth");

    // A write without a read grows the count by one.
    a_count_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && !w_rd) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue fill count did not grow on write");

    // A read without a write shrinks the count by one.
    a_count_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rd && !w_wr) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue fill count did not shrink on read");

endmodule

`default_nettype wire

@@ design/xrm_back.sv @@
// Back end: bit-serial remainder unit and the result register.
// Depends on xrm_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none

module xrm_back
    import xrm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_job        i_job,
    input  wire logic        i_job_valid,
    output logic             o_job_take,
    input  wire logic        i_pop,
    output logic             o_empty,
    output logic [63:0]      o_value,
    output logic [63:0]      o_next_seed
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_WAIT
    } t_state;

    t_state      r_state;
    logic [63:0] r_rem;
    logic [63:0] r_dvd;
    logic [63:0] r_div;
    logic [63:0] r_seed;
    logic [6:0]  r_cnt;
    logic        r_out_valid;
    logic        n_out_valid;
    logic [63:0] r_out_value;
    logic [63:0] r_out_next;
    logic        w_out_free;
    logic [64:0] w_shift;
    logic [64:0] w_diff;
    logic [63:0] n_rem;

    assign o_empty     = !r_out_valid;
    assign o_value     = r_out_value;
    assign o_next_seed = r_out_next;
    assign w_out_free  = !r_out_valid || i_pop;

    // Take a job when idle; a job without division also needs a free result slot.
    assign o_job_take = (r_state == S_IDLE) && i_job_valid
                        && (i_job.need_div || w_out_free);

    // One restoring division step: shift in the next dividend bit, subtract if it fits.
    assign w_shift = {r_rem, r_dvd[63]};
    assign w_diff  = w_shift - {1'b0, r_div};
    assign n_rem   = w_diff[64] ? w_shift[63:0] : w_diff[63:0];

    // The result slot empties on a pop and fills when a result is delivered.
    always_comb begin
        n_out_valid = r_out_valid && !i_pop;
        if (o_job_take && !i_job.need_div) begin
            n_out_valid = 1'b1;
        end
        if ((r_state == S_WAIT) && w_out_free) begin
            n_out_valid = 1'b1;
        end
    end

    // Sequencer, divider registers and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            case (r_state)
                S_IDLE: begin
                    if (o_job_take) begin
                        if (i_job.need_div) begin
                            r_rem   <= '0;
                            r_div   <= i_job.divisor;
                            r_seed  <= i_job.next_seed;
                            if (i_job.narrow) begin
                                r_dvd <= {i_job.dividend[31:0], 32'd0};
                                r_cnt <= 7'd32;
                            end else begin
                                r_dvd <= i_job.dividend;
                                r_cnt <= 7'd64;
                            end
                            r_state <= S_DIV;
                        end else begin
                            r_out_value <= i_job.dividend;
                            r_out_next  <= i_job.next_seed;
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_dvd <= {r_dvd[62:0], 1'b0};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == 7'd1) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (w_out_free) begin
                        r_out_value <= r_rem;
                        r_out_next  <= r_seed;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The partial remainder stays below a nonzero divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ((r_div != 64'd0) && (r_rem < r_div)))
        else $error("partial remainder out of range");

    // The step counter is never exhausted while dividing.
    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt != 7'd0))
        else $error("divider step count ran out");

    // A finished remainder goes to a free result slot in the next cycle.
    a_wait_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WAIT) && !r_out_valid) |=> ((r_state == S_IDLE) && r_out_valid))
        else $error("finished remainder not delivered");

endmodule

`default_nettype wire

@@ design/xorshift_random_modulo.sv @@
// Top level of the xorshift generator with modulo reduction.
// Depends on xrm_pkg, xrm_front, xrm_fifo and xrm_back.
//
//   Channel   Handshake          Payload
//   request   push / full        i_kind, i_modulus, i_seed_value
//   result    pop / empty        o_value, o_next_seed
//
// A request is taken when push is high and the queue is not full: the front end steps
// the generator and queues a job. A draw or step with a nonzero modulus is reduced in
// the bit-serial remainder unit over the low 32 (32-bit kinds) or all 64 (64-bit kinds)
// dividend bits; other kinds go straight to the result register. Reset loads both
// generator seeds and empties the queue, which lets requests enter while the remainder
// unit is busy. A held result stalls the back end, and requests once the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module xorshift_random_modulo
    import xrm_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  i_kind,
    input  wire logic [63:0] i_modulus,
    input  wire logic [63:0] i_seed_value,
    output logic             empty,
    input  wire logic        pop,
    output logic [63:0]      o_value,
    output logic [63:0]      o_next_seed
);

    t_job w_front_job;
    t_job w_back_job;
    logic w_accept;
    logic w_q_empty;
    logic w_take;

    assign w_accept = push && !full;

    // Request intake and generator states.
    xrm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_kind       (i_kind),
        .i_modulus    (i_modulus),
        .i_seed_value (i_seed_value),
        .o_job        (w_front_job)
    );

    // Job queue.
    xrm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_job   (w_front_job),
        .o_full  (full),
        .i_rd    (w_take),
        .o_job   (w_back_job),
        .o_empty (w_q_empty)
    );

    // Remainder unit and result register.
    xrm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_back_job),
        .i_job_valid (!w_q_empty),
        .o_job_take  (w_take),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_value     (o_value),
        .o_next_seed (o_next_seed)
    );

endmodule

`default_nettype wire

@@ tb/xorshift_random_modulo_tb.sv @@
// Self-checking testbench for xorshift_random_modulo: directed and random requests of every kind.
// Depends on xrm_pkg and the xorshift_random_modulo design; results are predicted in the bench.
`timescale 1ns / 1ps

module xorshift_random_modulo_tb
    import xrm_pkg::*;
();

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 6;
    localparam int MAX_IDLE        = 5;
    localparam int RANDOM_REQUESTS = 900;
    localparam int STRETCHES       = 6;
    localparam int DRAIN_CYCLES    = 80;
    localparam int CYCLE_LIMIT     = 400_000;

    // Kind codes that the block does not use.
    localparam logic [2:0] KIND_SPARE6 = 3'd6;
    localparam logic [2:0] KIND_SPARE7 = 3'd7;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    logic        i_clk;
    logic        i_rst_n      = 1'b0;
    logic        push         = 1'b0;
    logic [2:0]  i_kind       = '0;
    logic [63:0] i_modulus    = '0;
    logic [63:0] i_seed_value = '0;
    logic        pop          = 1'b0;
    logic        full;
    logic        empty;
    logic [63:0] o_value;
    logic [63:0] o_next_seed;

    xorshift_random_modulo DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_kind      (i_kind),
        .i_modulus   (i_modulus),
        .i_seed_value(i_seed_value),
        .empty       (empty),
        .pop         (pop),
        .o_value     (o_value),
        .o_next_seed (o_next_seed)
    );

    // One result the block owes, with the kind of its request for reporting.
    typedef struct {
        logic [2:0]  kind;
        logic [63:0] value;
        logic [63:0] next_seed;
    } t_random_result;

    t_random_result random_results_due[$];

    // The bench's own copy of both generator states.
    logic [31:0] narrow_seed = NARROW_RESET;
    logic [63:0] wide_seed   = WIDE_RESET;

    bit send_idle       = 1'b1;
    bit take_idle       = 1'b1;
    int error_count     = 0;
    int results_checked = 0;
    int requests_sent   = 0;
    int cycle_count     = 0;
    int pop_hold        = 0;
    int kind_count[8];

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // One 32-bit xorshift step, every shift term inverted.
    function automatic logic [31:0] advance32(input logic [31:0] s);
        logic [31:0] r;
        r = s;
        r = r ^ ~(r >> N_SHR);
        r = r ^ ~(r << N_SHL_A);
        r = r ^ ~(r << N_SHL_B);
        return r;
    endfunction

    // One 64-bit xorshift step, every shift term inverted.
    function automatic logic [63:0] advance64(input logic [63:0] s);
        logic [63:0] r;
        r = s;
        r = r ^ ~(r >> W_SHR);
        r = r ^ ~(r << W_SHL_A);
        r = r ^ ~(r << W_SHL_B);
        return r;
    endfunction

    // Works out the result of one request and updates the generator copies.
    function automatic t_random_result roll_random(input logic [2:0] kind,
                                                   input logic [63:0] modulus,
                                                   input logic [63:0] seed_value);
        t_random_result r;
        logic [31:0] m32;
        logic [31:0] s32;
        logic [63:0] s64;
        r.kind      = kind;
        r.value     = '0;
        r.next_seed = '0;
        m32 = modulus[31:0];
        case (kind)
            KIND_DRAW32: begin
                narrow_seed = advance32(narrow_seed);
                r.value     = {32'h0, (m32 != 0) ? narrow_seed % m32 : narrow_seed};
                r.next_seed = {32'h0, narrow_seed};
            end
            KIND_DRAW64: begin
                wide_seed   = advance64(wide_seed);
                r.value     = (modulus != 0) ? wide_seed % modulus : wide_seed;
                r.next_seed = wide_seed;
            end
            KIND_SEED32: begin
                r.value     = {32'h0, narrow_seed};
                narrow_seed = seed_value[31:0];
                r.next_seed = {32'h0, narrow_seed};
            end
            KIND_SEED64: begin
                r.value     = wide_seed;
                wide_seed   = seed_value;
                r.next_seed = wide_seed;
            end
            KIND_STEP32: begin
                s32         = advance32(seed_value[31:0]);
                r.value     = {32'h0, (m32 != 0) ? s32 % m32 : s32};
                r.next_seed = {32'h0, s32};
            end
            KIND_STEP64: begin
                s64         = advance64(seed_value);
                r.value     = (modulus != 0) ? s64 % modulus : s64;
                r.next_seed = s64;
            end
            default: begin
                // Unused kinds leave both states alone and return zeros.
            end
        endcase
        return r;
    endfunction

    function automatic logic [2:0] random_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 18) return KIND_DRAW32;
        if (r < 36) return KIND_DRAW64;
        if (r < 45) return KIND_SEED32;
        if (r < 54) return KIND_SEED64;
        if (r < 72) return KIND_STEP32;
        if (r < 92) return KIND_STEP64;
        return ($urandom_range(0, 1) == 0) ? KIND_SPARE6 : KIND_SPARE7;
    endfunction

    // Moduli weighted toward the interesting shapes: zero, tiny, one half empty, powers of two, all ones.
    function automatic logic [63:0] random_modulus();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 64'($urandom_range(1, 16));
            2:       return {32'h0, $urandom};
            3:       return {$urandom, 32'h0};
            4:       return 64'h1 << $urandom_range(0, 63);
            5:       return ALL_ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [63:0] random_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ALL_ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [2:0] kind,
                                   input logic [63:0] got, input logic [63:0] want);
        $display("mismatch at cycle %0d: %s (kind %0d): got %h, want %h",
                 cycle_count, what, kind, got, want);
        error_count++;
    endtask

    // Presents one request, holds it until the block takes it, then records its result.
    task automatic send_request(input logic [2:0] kind, input logic [63:0] modulus,
                                input logic [63:0] seed_value);
        int gap;
        gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push         <= 1'b1;
        i_kind       <= kind;
        i_modulus    <= modulus;
        i_seed_value <= seed_value;
        do @(posedge i_clk); while (full);
        random_results_due.push_back(roll_random(kind, modulus, seed_value));
        kind_count[kind]++;
        requests_sent++;
    endtask

    // Stops sending and waits until every owed result has come back.
    task automatic drain_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (random_results_due.size() != 0) @(posedge i_clk);
    endtask

    // Takes results with random stalls and compares each one against the oldest owed result.
    always @(posedge i_clk) begin : take_results
        t_random_result want;
        if (!i_rst_n) begin
            pop <= 1'b0;
            pop_hold = 0;
        end else begin
            if (pop && !empty) begin
                if (random_results_due.size() == 0) begin
                    report_mismatch("result with nothing owed", 3'd0, o_value, '0);
                end else begin
                    want = random_results_due.pop_front();
                    if (o_value !== want.value)
                        report_mismatch("value", want.kind, o_value, want.value);
                    if (o_next_seed !== want.next_seed)
                        report_mismatch("next_seed", want.kind, o_next_seed, want.next_seed);
                    results_checked++;
                end
                pop_hold = take_idle ? $urandom_range(0, MAX_IDLE) : 0;
            end
            if (pop_hold > 0) begin
                pop <= 1'b0;
                pop_hold--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, random_results_due.size());
            $display("status: fail");
            $finish;
        end
    end

    // The first draws after reset expose both reset seeds.
    task automatic test_reset_seeds();
        send_request(KIND_DRAW32, '0, '0);
        send_request(KIND_DRAW64, '0, '0);
        drain_results();
    endtask

    // Modulus at its extremes; 32-bit draws must ignore the upper half.
    task automatic test_modulus_extremes();
        send_request(KIND_DRAW32, 64'h1, '0);
        send_request(KIND_DRAW32, 64'hFFFF_FFFF, '0);
        send_request(KIND_DRAW32, 64'hFFFF_FFFF_0000_0000, ALL_ONES);
        send_request(KIND_DRAW32, 64'h1234_5678_0000_0007, '0);
        send_request(KIND_DRAW64, 64'h1, '0);
        send_request(KIND_DRAW64, ALL_ONES, '0);
        send_request(KIND_DRAW64, 64'h8000_0000_0000_0000, '0);
        send_request(KIND_DRAW64, 64'h0000_0000_FFFF_FFFF, '0);
        drain_results();
    endtask

    // Seed writes return the old state; 32-bit writes keep only the low half.
    task automatic test_seed_writes();
        send_request(KIND_SEED32, ALL_ONES, ALL_ONES);
        send_request(KIND_DRAW32, 64'h3, '0);
        send_request(KIND_SEED32, '0, '0);
        send_request(KIND_DRAW32, '0, '0);
        send_request(KIND_SEED64, '0, ALL_ONES);
        send_request(KIND_SEED64, ALL_ONES, '0);
        send_request(KIND_DRAW64, 64'd10, '0);
        drain_results();
    endtask

    // External steps use the supplied seed and leave the internal states alone.
    task automatic test_external_steps();
        send_request(KIND_STEP32, '0, '0);
        send_request(KIND_STEP32, 64'h7, ALL_ONES);
        send_request(KIND_STEP32, 64'hFFFF_FFFF_0000_0000, 64'hDEAD_BEEF_0000_0001);
        send_request(KIND_STEP64, '0, '0);
        send_request(KIND_STEP64, ALL_ONES, ALL_ONES);
        drain_results();
    endtask

    // Unused kinds return zeros and change nothing.
    task automatic test_unused_kinds();
        send_request(KIND_SPARE6, ALL_ONES, ALL_ONES);
        send_request(KIND_SPARE7, ALL_ONES, ALL_ONES);
        drain_results();
    endtask

    // Random mix in stretches with different idling on each side.
    task automatic test_random_traffic();
        int stretch;
        int n;
        for (stretch = 0; stretch < STRETCHES; stretch++) begin
            send_idle = (stretch % 3) != 1;
            take_idle = (stretch % 2) == 0;
            for (n = 0; n < RANDOM_REQUESTS / STRETCHES; n++)
                send_request(random_kind(), random_modulus(), random_word());
        end
        send_idle = 1'b1;
        take_idle = 1'b1;
        drain_results();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_seeds();
        test_modulus_extremes();
        test_seed_writes();
        test_external_steps();
        test_unused_kinds();
        test_random_traffic();

        // Let any stray result from the remainder unit show up before judging.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests and checked %0d results in %0d cycles.",
                 requests_sent, results_checked, cycle_count);
        $display("Per kind: draw32 %0d, draw64 %0d, seed32 %0d, seed64 %0d, step32 %0d, %s %0d",
                 kind_count[KIND_DRAW32], kind_count[KIND_DRAW64], kind_count[KIND_SEED32],
                 kind_count[KIND_SEED64], kind_count[KIND_STEP32],
                 "step64", kind_count[KIND_STEP64]);
        if (error_count == 0 && random_results_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     error_count, random_results_due.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/xrm_pkg.sv
design/xrm_front.sv
design/xrm_fifo.sv
design/xrm_back.sv
design/xorshift_random_modulo.sv
tb/xorshift_random_modulo_tb.sv
